>>> rtl/hpdl_pkg.sv
// ----------------------------------------------------------------------------
// hpdl_pkg
// Shared widths, codes and types of the horizon price direction labeler.
// ----------------------------------------------------------------------------
package hpdl_pkg;

    localparam int TS_W      = 48;
    localparam int PRICE_W   = 32;
    localparam int ROW_W     = 32;
    localparam int HORIZON_W = 32;

    localparam int PENDING_DEPTH_DEF = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index taken from paddr[2]
    localparam logic REG_HORIZON = 1'b0;

    localparam logic [HORIZON_W-1:0] HORIZON_RESET = HORIZON_W'(1000);

    localparam logic STATUS_LABELED = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef enum logic {
        K_CONTINUE,
        K_NEW_SET
    } t_kind;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [PRICE_W-1:0] price;
        t_kind              kind;
    } t_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic take;
        logic emit;
        logic drop;
        logic pop;
        logic push;
        logic to_out;
        logic flush;
    } t_back_ctl;

endpackage

>>> rtl/hpdl_front.sv
// ----------------------------------------------------------------------------
// hpdl_front
// Accepts rows, tags rows that open a new set, and holds them in a short queue.
// ----------------------------------------------------------------------------
module hpdl_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hpdl_pkg::TS_W-1:0]    i_timestamp_ms,
    input  logic [hpdl_pkg::PRICE_W-1:0] i_mid_price,
    input  logic                        i_starts_new_set,
    output logic                        o_item_valid,
    output hpdl_pkg::t_item             o_item,
    input  logic                        i_item_take
);
    import hpdl_pkg::*;

    t_item               r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_fill;
    logic                accept;
    t_item               new_item;

    function automatic logic [QUEUE_AW-1:0] q_next(input logic [QUEUE_AW-1:0] p);
        q_next = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_stall   = (r_fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign accept       = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_queue[r_rd_ptr];

    always_comb begin
        new_item.ts    = i_timestamp_ms;
        new_item.price = i_mid_price;
        new_item.kind  = i_starts_new_set ? K_NEW_SET : K_CONTINUE;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= q_next(r_wr_ptr);
            end
            if (i_item_take) begin
                r_rd_ptr <= q_next(r_rd_ptr);
            end
            unique case ({accept, i_item_take})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

>>> rtl/hpdl_back.sv
// ----------------------------------------------------------------------------
// hpdl_back
// Pending row store and labelling sequencer with a result hold and output stage.
// ----------------------------------------------------------------------------
module hpdl_back #(
    parameter int PENDING_DEPTH = hpdl_pkg::PENDING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hpdl_pkg::HORIZON_W-1:0] i_horizon,
    input  logic                          i_item_valid,
    input  hpdl_pkg::t_item               i_item,
    output logic                          o_item_take,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hpdl_pkg::ROW_W-1:0]     o_row_index,
    output logic                          o_label,
    output logic                          o_status,
    output logic                          o_last_of_run
);
    import hpdl_pkg::*;

    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    logic [TS_W-1:0]    r_mem_time  [PENDING_DEPTH];
    logic [PRICE_W-1:0] r_mem_price [PENDING_DEPTH];
    logic [TS_W-1:0]    r_rd_time;
    logic [PRICE_W-1:0] r_rd_price;

    t_state             r_state;
    t_state             n_state;
    t_back_ctl          ctl;

    logic [TS_W-1:0]    r_ts;
    logic [PRICE_W-1:0] r_price;
    logic [PW-1:0]      r_rp;
    logic [PW-1:0]      r_wp;
    logic [CW-1:0]      r_count;
    logic [ROW_W-1:0]   r_row;

    logic               r_hold_valid;
    logic [ROW_W-1:0]   r_hold_row;
    logic               r_hold_label;
    logic               r_hold_status;

    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_label;
    logic               r_out_status;
    logic               r_out_last;

    logic [TS_W:0]      due_sum;
    logic               head_due;
    logic               full;
    logic               out_free;
    logic               emit_ok;

    function automatic logic [PW-1:0] p_next(input logic [PW-1:0] p);
        p_next = (p == PW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign due_sum  = {1'b0, r_rd_time} + {{(TS_W + 1 - HORIZON_W){1'b0}}, i_horizon};
    assign head_due = (r_count != '0) && (due_sum <= {1'b0, r_ts});
    assign full     = (r_count == CW'(PENDING_DEPTH));
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_ok  = !r_hold_valid || out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                priority if (head_due) begin
                    n_state = emit_ok ? S_READ : S_TEST;
                end else if (full) begin
                    n_state = emit_ok ? S_PUSH : S_TEST;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_hold_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                ctl.take = i_item_valid;
            end
            S_READ: begin
                ctl = '0;
            end
            S_TEST: begin
                priority if (head_due) begin
                    ctl.emit   = emit_ok;
                    ctl.pop    = emit_ok;
                    ctl.to_out = emit_ok && r_hold_valid;
                end else if (full) begin
                    ctl.emit   = emit_ok;
                    ctl.drop   = emit_ok;
                    ctl.pop    = emit_ok;
                    ctl.to_out = emit_ok && r_hold_valid;
                end else begin
                    ctl = '0;
                end
            end
            S_PUSH: begin
                ctl.push   = !r_hold_valid || out_free;
                ctl.to_out = r_hold_valid && out_free;
                ctl.flush  = r_hold_valid && out_free;
            end
            default: ctl = '0;
        endcase
    end

    assign o_item_take = ctl.take;

    always_ff @(posedge i_clk) begin
        if (ctl.push) begin
            r_mem_time[r_wp]  <= r_ts;
            r_mem_price[r_wp] <= r_price;
        end
        r_rd_time  <= r_mem_time[r_rp];
        r_rd_price <= r_mem_price[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.take) begin
            r_ts    <= i_item.ts;
            r_price <= i_item.price;
        end
        if (ctl.emit) begin
            r_hold_row    <= r_row;
            r_hold_label  <= ctl.drop ? 1'b0 : (r_price > r_rd_price);
            r_hold_status <= ctl.drop ? STATUS_DROPPED : STATUS_LABELED;
        end
        if (ctl.to_out) begin
            r_out_row    <= r_hold_row;
            r_out_label  <= r_hold_label;
            r_out_status <= r_hold_status;
            r_out_last   <= ctl.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rp         <= '0;
            r_wp         <= '0;
            r_count      <= '0;
            r_row        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.take && (i_item.kind == K_NEW_SET)) begin
                r_rp    <= '0;
                r_wp    <= '0;
                r_count <= '0;
                r_row   <= '0;
            end
            if (ctl.pop) begin
                r_rp    <= p_next(r_rp);
                r_count <= r_count - 1'b1;
                r_row   <= r_row + 1'b1;
            end
            if (ctl.push) begin
                r_wp    <= p_next(r_wp);
                r_count <= r_count + 1'b1;
            end
            if (ctl.emit) begin
                r_hold_valid <= 1'b1;
            end else if (ctl.flush) begin
                r_hold_valid <= 1'b0;
            end
            if (ctl.to_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_index   = r_out_row;
    assign o_label       = r_out_label;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PENDING_DEPTH))
        else $error("pending count above depth");

    a_drop_unlabeled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STATUS_DROPPED)) |-> !r_out_label)
        else $error("dropped row carries a label");

    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.push |=> (r_count != '0))
        else $error("store empty after push");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_rp == r_wp))
        else $error("pointers differ while store empty");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.to_out |-> out_free)
        else $error("output stage overwritten while stalled");
`endif

endmodule

>>> rtl/horizon_price_direction_labeler.sv
// ----------------------------------------------------------------------------
// horizon_price_direction_labeler
// Labels each row by whether the price one horizon later is strictly higher.
//
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  timestamp_ms, mid_price,
//                                               starts_new_set
// out       output     o_out_valid / i_out_stall row_index, label, status,
//                                               last_of_run
// cfg       input      apb write, pready high   horizon_ms at paddr 0
//
// a row passes through the idle, read, test and push states of the sequencer,
// and each labelled result adds a return to read, set by the registered read
// of the pending store at the read pointer; an overflow drop adds none
// a two-entry queue takes rows while the sequencer is busy
// reset is synchronous and active low; the pending store is not cleared
// a stalled output holds the sequencer before its next result and before
// the push that ends a row
// ----------------------------------------------------------------------------
module horizon_price_direction_labeler #(
    parameter int PENDING_DEPTH = hpdl_pkg::PENDING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hpdl_pkg::TS_W-1:0]      i_timestamp_ms,
    input  logic [hpdl_pkg::PRICE_W-1:0]   i_mid_price,
    input  logic                          i_starts_new_set,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hpdl_pkg::ROW_W-1:0]     o_row_index,
    output logic                          o_label,
    output logic                          o_status,
    output logic                          o_last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpdl_pkg::APB_AW-1:0]    paddr,
    input  logic [hpdl_pkg::APB_DW-1:0]    pwdata,
    output logic [hpdl_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import hpdl_pkg::*;

    logic [HORIZON_W-1:0] r_horizon;
    logic                 item_valid;
    t_item                item;
    logic                 item_take;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= HORIZON_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_HORIZON)) begin
            r_horizon <= pwdata[HORIZON_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_HORIZON) ? APB_DW'(r_horizon) : '0;

    hpdl_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_timestamp_ms   (i_timestamp_ms),
        .i_mid_price      (i_mid_price),
        .i_starts_new_set (i_starts_new_set),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_item_take      (item_take)
    );

    hpdl_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_horizon     (r_horizon),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_take   (item_take),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_index   (o_row_index),
        .o_label       (o_label),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rows into the horizon price direction labeler and checks every
// result against the directed table or an in-bench predictor of the pending
// row fifo. A short table of directed rows comes first, then random sets of
// rows under several horizon settings written over the apb port, with random
// idling on both sides, one quiet stretch and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import hpdl_pkg::*;

    localparam int FIFO_DEPTH     = PENDING_DEPTH_DEF;
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int ROWS_PER_PHASE = 55;
    localparam int NUM_PHASES     = 7;
    localparam int HOLD_PHASE     = 1;
    localparam int CALM_PHASE     = 4;
    localparam int NUM_PROBES     = 16;

    localparam logic [APB_AW-1:0] HORIZON_ADDR = {REG_HORIZON, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR   = {~REG_HORIZON, 2'b00};

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             label;
        logic             status;
        logic             last;
    } t_label_res;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [PRICE_W-1:0] price;
        t_kind              kind;
        int                 reps;
        bit                 typed;
        int                 n_results;
        logic [ROW_W-1:0]   row;
        logic               label;
        logic               status;
    } t_probe;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [TS_W-1:0]      i_timestamp_ms;
    logic [PRICE_W-1:0]   i_mid_price;
    logic                 i_starts_new_set;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ROW_W-1:0]     o_row_index;
    logic                 o_label;
    logic                 o_status;
    logic                 o_last_of_run;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state
    logic [TS_W-1:0]      open_ts[$];
    logic [PRICE_W-1:0]   open_price[$];
    logic [ROW_W-1:0]     next_label_row;
    logic [HORIZON_W-1:0] horizon_now;

    t_label_res           fresh_labels[$];
    t_label_res           awaited_labels[$];
    t_label_res           head_want;

    t_probe               probe_table [NUM_PROBES];
    logic [HORIZON_W-1:0] phase_horizon [NUM_PHASES];

    logic [TS_W-1:0]      cur_ts;
    logic [PRICE_W-1:0]   cur_price;
    int                   set_left;
    int                   span_shift;

    int                   mismatches;
    int                   quiet_cycles;
    int                   hold_left;
    bit                   hold_ask;
    bit                   calm;

    horizon_price_direction_labeler u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_timestamp_ms   (i_timestamp_ms),
        .i_mid_price      (i_mid_price),
        .i_starts_new_set (i_starts_new_set),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_row_index      (o_row_index),
        .o_label          (o_label),
        .o_status         (o_status),
        .o_last_of_run    (o_last_of_run),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 50) begin
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        end
    endtask

    function automatic void label_row(logic [TS_W-1:0] ts, logic [PRICE_W-1:0] price,
                                      t_kind kind);
        t_label_res r;
        fresh_labels.delete();
        if (kind == K_NEW_SET) begin
            open_ts.delete();
            open_price.delete();
            next_label_row = '0;
        end
        while (open_ts.size() > 0 && {1'b0, open_ts[0]} + horizon_now <= {1'b0, ts}) begin
            r = '{next_label_row, price > open_price[0], STATUS_LABELED, 1'b0};
            fresh_labels.push_back(r);
            void'(open_ts.pop_front());
            void'(open_price.pop_front());
            next_label_row++;
        end
        if (open_ts.size() >= FIFO_DEPTH) begin
            r = '{next_label_row, 1'b0, STATUS_DROPPED, 1'b0};
            fresh_labels.push_back(r);
            void'(open_ts.pop_front());
            void'(open_price.pop_front());
            next_label_row++;
        end
        open_ts.push_back(ts);
        open_price.push_back(price);
        if (fresh_labels.size() > 0) begin
            fresh_labels[fresh_labels.size() - 1].last = 1'b1;
        end
    endfunction

    // offers one row and predicts its labels once the transaction is taken
    task automatic send_row(logic [TS_W-1:0] ts, logic [PRICE_W-1:0] price, t_kind kind,
                            bit use_model);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_timestamp_ms   <= ts;
        i_mid_price      <= price;
        i_starts_new_set <= (kind == K_NEW_SET);
        do @(posedge i_clk); while (o_in_stall);
        label_row(ts, price, kind);
        if (use_model) begin
            foreach (fresh_labels[j]) awaited_labels.push_back(fresh_labels[j]);
        end
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_HORIZON) begin
            horizon_now = data;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_labels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_rows(int count);
        t_kind kind;
        int    r;
        repeat (count) begin
            kind = K_CONTINUE;
            if (set_left == 0 || $urandom_range(0, 49) == 0) begin
                kind       = K_NEW_SET;
                set_left   = $urandom_range(1, 70);
                span_shift = $urandom_range(1, 7);
                r = $urandom_range(0, 7);
                if (r == 0) begin
                    cur_ts = '0;
                end else if (r == 1) begin
                    cur_ts = {TS_W{1'b1}} - TS_W'($urandom_range(0, 3000));
                end else begin
                    cur_ts = TS_W'({$urandom, $urandom});
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    cur_ts = cur_ts - TS_W'($urandom_range(0, 40));
                end else if (r < 12) begin
                    cur_ts = cur_ts + horizon_now - 1 + TS_W'($urandom_range(0, 2));
                end else if (r < 15) begin
                    cur_ts = cur_ts + (TS_W'(1) << 33);
                end else begin
                    cur_ts = cur_ts + TS_W'($urandom_range(0, (horizon_now >> span_shift) + 2));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                cur_price = $urandom;
            end else begin
                cur_price = cur_price + PRICE_W'($urandom_range(0, 4)) - 2;
            end
            if (set_left > 0) set_left--;
            send_row(cur_ts, cur_price, kind, 1'b1);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_labels.size() == 0) begin
                report_mismatch("unexpected transaction, row_index", o_row_index, 0);
            end else begin
                head_want = awaited_labels.pop_front();
                if (o_row_index !== head_want.row)
                    report_mismatch("row_index", o_row_index, head_want.row);
                if (o_label !== head_want.label)
                    report_mismatch("label", o_label, head_want.label);
                if (o_status !== head_want.status)
                    report_mismatch("status", o_status, head_want.status);
                if (o_last_of_run !== head_want.last)
                    report_mismatch("last_of_run", o_last_of_run, head_want.last);
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_ask) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_ask    <= 1'b0;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 8);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_timestamp_ms   = '0;
        i_mid_price      = '0;
        i_starts_new_set = 1'b0;
        i_out_stall      = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        mismatches       = 0;
        quiet_cycles     = 0;
        hold_left        = 0;
        hold_ask         = 1'b0;
        calm             = 1'b0;
        set_left         = 0;
        span_shift       = 1;
        cur_ts           = '0;
        cur_price        = '0;
        next_label_row   = '0;
        horizon_now      = HORIZON_RESET;

        // ts, price, kind, reps, typed, results, row, label, status
        probe_table = '{
            '{48'd0,    32'd100, K_NEW_SET,  1,  1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            '{48'd999,  32'd200, K_CONTINUE, 1,  1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            '{48'd1000, 32'd101, K_CONTINUE, 1,  1'b1, 1, 32'd0, 1'b1, STATUS_LABELED},
            // equal price at exactly the horizon
            '{48'd1999, 32'd200, K_CONTINUE, 1,  1'b1, 1, 32'd1, 1'b0, STATUS_LABELED},
            // out of order row
            '{48'd1500, 32'd5,   K_CONTINUE, 1,  1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            // later row has reached its horizon but the head has not
            '{48'd2600, 32'd7,   K_CONTINUE, 1,  1'b1, 1, 32'd2, 1'b0, STATUS_LABELED},
            '{48'd3000, 32'd50,  K_CONTINUE, 1,  1'b0, 0, 32'd0, 1'b0, STATUS_LABELED},
            // new set discards pending rows
            '{48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, K_NEW_SET, 1, 1'b1, 0, 32'd0, 1'b0,
              STATUS_LABELED},
            // horizon sum must not wrap
            '{48'hFFFF_FFFF_FFFF, 32'd0, K_CONTINUE, 1, 1'b1, 0, 32'd0, 1'b0,
              STATUS_LABELED},
            '{48'd0,    32'd0,   K_NEW_SET,  1,  1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            '{48'd1000, 32'hFFFF_FFFF, K_CONTINUE, 1, 1'b1, 1, 32'd0, 1'b1, STATUS_LABELED},
            '{48'd2000, 32'd0,   K_CONTINUE, 1,  1'b1, 1, 32'd1, 1'b0, STATUS_LABELED},
            // fill the fifo, then overflow drops the oldest
            '{48'd5,    32'd10,  K_NEW_SET,  1,  1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            '{48'd5,    32'd20,  K_CONTINUE, 31, 1'b1, 0, 32'd0, 1'b0, STATUS_LABELED},
            '{48'd5,    32'd30,  K_CONTINUE, 1,  1'b1, 1, 32'd0, 1'b0, STATUS_DROPPED},
            '{48'd1005, 32'd25,  K_CONTINUE, 1,  1'b0, 0, 32'd0, 1'b0, STATUS_LABELED}
        };

        phase_horizon = '{32'd0, 32'd1, 32'd37, 32'hFFFF_FFFF, 32'd2500, $urandom, 32'd1000};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_table[k]) begin
            repeat (probe_table[k].reps) begin
                send_row(probe_table[k].ts, probe_table[k].price, probe_table[k].kind,
                         !probe_table[k].typed);
                if (probe_table[k].typed && probe_table[k].n_results == 1) begin
                    awaited_labels.push_back('{probe_table[k].row, probe_table[k].label,
                                               probe_table[k].status, 1'b1});
                end
            end
        end

        foreach (phase_horizon[p]) begin
            drain_and_settle();
            apb_write(SPARE_ADDR, $urandom);
            apb_write(HORIZON_ADDR, phase_horizon[p]);
            calm = (p == CALM_PHASE);
            if (p == HOLD_PHASE) hold_ask = 1'b1;
            random_rows(ROWS_PER_PHASE);
        end
        drain_and_settle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
